// ===== hdl/frp_pkg.sv =====
// Package for the framed packet receiver: sync constants, register map
// and output flag positions. No dependencies.
package frp_pkg;

  localparam logic [7:0] SYNC_FIRST   = 8'hEF;
  localparam logic [7:0] SYNC_SECOND  = 8'hFF;
  localparam logic [7:0] OWN_ID_RESET = 8'h01;

  // Register index within the configuration map
  localparam logic REG_OWN_ID = 1'b0;

  // Bit positions of the result flags in m_axis_tuser
  localparam int unsigned USER_ACCEPTED      = 0;
  localparam int unsigned USER_PAYLOAD_VALID = 1;
  localparam int unsigned USER_FRAME_END     = 2;
  localparam int unsigned USER_FRAME_GOOD    = 3;
  localparam int unsigned USER_W             = 4;

endpackage

// ===== hdl/framed_packet_receiver_top.sv =====
// Framed packet receiver with an 8-bit additive checksum: top level.
// Depends on frp_pkg.
//
// One received byte per beat enters on s_axis and yields exactly one result
// beat on m_axis. The receiver hunts for 0xEF, 0xFF, then the own_id byte,
// then a length byte, that many payload bytes and a check byte equal to the
// 8-bit sum of all bytes from the first sync byte on. A byte is taken in every
// cycle in which the result register is empty or being emptied; the result is
// registered and appears in the cycle after its byte. One byte is taken per
// clock unless m_axis stalls, the frame state and running sum being updated
// with each byte. own_id is written through the APB port at byte address 0.
module framed_packet_receiver_top
  import frp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // APB configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // Input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] rx_byte
  // Result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata,   // [7:0] payload_byte, [15:8] payload_index
  output logic [USER_W-1:0] m_axis_tuser    // [0] accepted, [1] payload_valid,
                                            // [2] frame_end, [3] frame_good
);

  typedef enum logic [2:0] {
    PH_SYNC1   = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_ID      = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5
  } phase_e;

  logic [7:0] own_id_q;
  phase_e     phase_q, phase_d;
  logic [7:0] count_q, count_d;
  logic [7:0] length_q, length_d;
  logic [7:0] sum_q, sum_d;

  logic              out_valid_q;
  logic [15:0]       out_data_q, out_data_d;
  logic [USER_W-1:0] out_user_q, out_user_d;

  logic       in_beat;
  logic       cfg_write;
  logic [7:0] b;
  logic [7:0] sum_plus;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign prdata    = (paddr[2] == REG_OWN_ID) ? {24'd0, own_id_q} : 32'd0;

  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign in_beat       = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  assign b        = s_axis_tdata;
  assign sum_plus = sum_q + b;

  always_comb begin
    phase_d    = phase_q;
    count_d    = count_q;
    length_d   = length_q;
    sum_d      = sum_q;
    out_data_d = 16'd0;
    out_user_d = '0;
    unique case (phase_q)
      PH_SYNC1: begin
        if (b == SYNC_FIRST) begin
          sum_d   = sum_plus;
          phase_d = PH_SYNC2;
          out_user_d[USER_ACCEPTED] = 1'b1;
        end
      end
      PH_SYNC2: begin
        if (b == SYNC_SECOND) begin
          sum_d   = sum_plus;
          phase_d = PH_ID;
          out_user_d[USER_ACCEPTED] = 1'b1;
        end
      end
      PH_ID: begin
        if (b == own_id_q) begin
          sum_d   = sum_plus;
          count_d = 8'd0;
          phase_d = PH_LEN;
          out_user_d[USER_ACCEPTED] = 1'b1;
        end
      end
      PH_LEN: begin
        sum_d    = sum_plus;
        length_d = b;
        count_d  = 8'd0;
        phase_d  = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
        out_user_d[USER_ACCEPTED] = 1'b1;
      end
      PH_PAYLOAD: begin
        sum_d      = sum_plus;
        count_d    = count_q + 8'd1;
        out_data_d = {count_q, b};
        out_user_d[USER_ACCEPTED]      = 1'b1;
        out_user_d[USER_PAYLOAD_VALID] = 1'b1;
        if (count_d == length_q) begin
          phase_d = PH_CHECK;
        end
      end
      PH_CHECK: begin
        out_user_d[USER_ACCEPTED]   = 1'b1;
        out_user_d[USER_FRAME_END]  = 1'b1;
        out_user_d[USER_FRAME_GOOD] = (b == sum_q);
        phase_d = PH_SYNC1;
        sum_d   = 8'd0;
      end
      default: begin
        phase_d = PH_SYNC1;
        sum_d   = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q    <= OWN_ID_RESET;
      phase_q     <= PH_SYNC1;
      count_q     <= 8'd0;
      length_q    <= 8'd0;
      sum_q       <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_write && paddr[2] == REG_OWN_ID) begin
        own_id_q <= pwdata[7:0];
      end
      if (in_beat) begin
        phase_q     <= phase_d;
        count_q     <= count_d;
        length_q    <= length_d;
        sum_q       <= sum_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  a_good_needs_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_user_q[USER_FRAME_GOOD] |-> out_user_q[USER_FRAME_END])
    else $error("frame_good without frame_end");

  a_payload_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_user_q[USER_PAYLOAD_VALID] |-> out_user_q[USER_ACCEPTED])
    else $error("payload beat not marked accepted");

  a_index_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_user_q[USER_PAYLOAD_VALID] |-> out_data_q[15:8] < length_q)
    else $error("payload index beyond frame length");

  a_check_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && phase_q == PH_CHECK |=> phase_q == PH_SYNC1 && sum_q == 8'd0)
    else $error("check byte did not return to idle with cleared sum");

endmodule
